@@ rtl/core/health_aware_server_selector_defines.svh @@
// ---------------------------------------------------------------------------
// Health-aware server selector: assertion macros
// Shared check macros used by the selector RTL.
// ---------------------------------------------------------------------------
`ifndef HEALTH_AWARE_SERVER_SELECTOR_DEFINES_SVH
`define HEALTH_AWARE_SERVER_SELECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HASS_CHECK(lbl, pre, post) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(pre) |-> (post)) else $error("selector check failed");
`define HASS_NEXT(lbl, pre, post) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(pre) |=> (post)) else $error("selector check failed");
`else
`define HASS_CHECK(lbl, pre, post)
`define HASS_NEXT(lbl, pre, post)
`endif

`endif

@@ rtl/core/hass_pkg.sv @@
// ---------------------------------------------------------------------------
// hass_pkg
// Types, codes and constants of the health-aware server selector.
// ---------------------------------------------------------------------------
`default_nettype none
package hass_pkg;
	localparam int MAX_SERVERS_DEF = 16;

	localparam logic [29:0] HASH_MOD = 30'd1000000007;
	localparam int HASH_BITS = 30;

	localparam logic [1:0] REQ_ADD  = 2'd0;
	localparam logic [1:0] REQ_SEL  = 2'd1;
	localparam logic [1:0] REQ_BYTE = 2'd2;

	localparam logic [1:0] MODE_RR   = 2'd0;
	localparam logic [1:0] MODE_WRR  = 2'd1;
	localparam logic [1:0] MODE_LC   = 2'd2;
	localparam logic [1:0] MODE_HASH = 2'd3;

	localparam logic [2:0] STAT_PICK     = 3'd0;
	localparam logic [2:0] STAT_FALLBACK = 3'd1;
	localparam logic [2:0] STAT_EMPTY    = 3'd2;
	localparam logic [2:0] STAT_ADDED    = 3'd3;
	localparam logic [2:0] STAT_FULL     = 3'd4;

	typedef struct packed {
		logic [7:0]  weight;
		logic [15:0] conns;
		logic        healthy;
	} entry_t;
endpackage
`default_nettype wire

@@ rtl/core/hass_ram.sv @@
// ---------------------------------------------------------------------------
// hass_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module hass_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/health_aware_server_selector.sv @@
// Add: result in the cycle after the request. Address byte: updates the hash, no result.
// Select: round robin, least connections, weighted and hash picks walk the entries with
// one shared entry RAM read per step; the hash pick first takes the hash modulo the entry count.
// Results are a one-cycle done strobe; the receiver cannot stall.
// arst_n clears the table count, pointers, hash and mode; the RAM is not cleared.
// ---------------------------------------------------------------------------
// health_aware_server_selector
// Server table with round robin, weighted, least-connection and hash picks.
// ---------------------------------------------------------------------------
`default_nettype none
`include "health_aware_server_selector_defines.svh"
module health_aware_server_selector #(
	parameter int MAX_SERVERS = hass_pkg::MAX_SERVERS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [7:0]  weight,
	input  wire logic [15:0] connections,
	input  wire logic        healthy,
	input  wire logic [7:0]  ip_byte,
	output logic             done,
	output logic [3:0]       server_index,
	output logic [2:0]       status
);
	import hass_pkg::*;

	localparam int IW = $clog2(MAX_SERVERS);
	localparam int CW = $clog2(MAX_SERVERS + 1);
	localparam int TW = $clog2(MAX_SERVERS * 255 + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_HRED  = 3'd1;
	localparam logic [2:0] S_HMOD  = 3'd2;
	localparam logic [2:0] S_FETCH = 3'd3;
	localparam logic [2:0] S_CHECK = 3'd4;

	localparam logic [2:0] OP_RR = 3'd0;
	localparam logic [2:0] OP_HP = 3'd1;
	localparam logic [2:0] OP_LC = 3'd2;
	localparam logic [2:0] OP_W1 = 3'd3;
	localparam logic [2:0] OP_W2 = 3'd4;

	logic [2:0]    state_q;
	logic [2:0]    op_q;
	logic [1:0]    mode_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] rot_q;
	logic [TW-1:0] wpos_q;
	logic [29:0]   hash_q;
	logic          done_q;
	logic [3:0]    sidx_q;
	logic [2:0]    stat_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] k_q;
	logic [35:0]   v_q;
	logic [2:0]    red_q;
	logic [4:0]    bit_q;
	logic [29:0]   hsh_q;
	logic [CW-1:0] rem_q;
	logic [TW-1:0] tot_q;
	logic [TW-1:0] slot_q;
	logic [TW-1:0] end_q;
	logic [IW-1:0] own_q;
	logic          ofnd_q;
	logic [IW-1:0] fidx_q;
	logic          ffnd_q;
	logic          first_q;
	logic [15:0]   best_q;
	logic [IW-1:0] pick_q;
	logic          lfnd_q;

	entry_t rd;
	entry_t wr;
	logic   accept;
	logic   ram_we;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign ram_we = accept && (req_type == REQ_ADD) && (count_q < CW'(MAX_SERVERS));
	assign wr     = '{weight: weight, conns: connections, healthy: healthy};

	hass_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_SERVERS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IW-1:0]),
		.wdata (wr),
		.re    (state_q == S_FETCH),
		.raddr (idx_q),
		.rdata (rd)
	);

	assign pready       = 1'b1;
	assign prdata       = paddr[2] ? 32'd0 : {30'd0, mode_q};
	assign done         = done_q;
	assign server_index = sidx_q;
	assign status       = stat_q;

	logic [CW-1:0] idx_inc;
	logic          last;
	logic [IW-1:0] idx_nxt;
	logic [35:0]   sub;
	logic [CW:0]   rs;
	logic [CW:0]   rs_red;
	logic [TW-1:0] w_ext;
	logic [TW-1:0] tsum;
	logic [TW-1:0] slot_inc;
	logic [TW-1:0] seg_end;
	logic          own_hit;

	assign idx_inc  = CW'(idx_q) + CW'(1);
	assign idx_nxt  = (idx_inc == count_q) ? '0 : idx_inc[IW-1:0];
	assign last     = (k_q == count_q - CW'(1));
	assign sub      = 36'(HASH_MOD) << red_q;
	assign rs       = {rem_q, hsh_q[29]};
	assign rs_red   = (rs >= {1'b0, count_q}) ? rs - {1'b0, count_q} : rs;
	assign w_ext    = TW'(rd.weight);
	assign tsum     = tot_q + w_ext;
	assign slot_inc = slot_q + TW'(1);
	assign seg_end  = first_q ? end_q : slot_q + w_ext;
	assign own_hit  = !ofnd_q && (wpos_q < tsum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_RR;
			mode_q  <= MODE_RR;
			count_q <= '0;
			rot_q   <= '0;
			wpos_q  <= '0;
			hash_q  <= '0;
			done_q  <= 1'b0;
			sidx_q  <= '0;
			stat_q  <= STAT_PICK;
			idx_q   <= '0;
			k_q     <= '0;
			v_q     <= '0;
			red_q   <= '0;
			bit_q   <= '0;
			hsh_q   <= '0;
			rem_q   <= '0;
			tot_q   <= '0;
			slot_q  <= '0;
			end_q   <= '0;
			own_q   <= '0;
			ofnd_q  <= 1'b0;
			fidx_q  <= '0;
			ffnd_q  <= 1'b0;
			first_q <= 1'b0;
			best_q  <= '0;
			pick_q  <= '0;
			lfnd_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (psel && penable && pwrite && !paddr[2]) begin
				mode_q <= pwdata[1:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req_type)
							REQ_ADD: begin
								done_q <= 1'b1;
								if (count_q < CW'(MAX_SERVERS)) begin
									sidx_q  <= 4'(count_q);
									stat_q  <= STAT_ADDED;
									count_q <= count_q + CW'(1);
								end else begin
									sidx_q <= '0;
									stat_q <= STAT_FULL;
								end
							end
							REQ_SEL: begin
								hash_q <= '0;
								k_q    <= '0;
								if (count_q == '0) begin
									done_q <= 1'b1;
									sidx_q <= '0;
									stat_q <= STAT_EMPTY;
								end else begin
									unique case (mode_q)
										MODE_RR: begin
											op_q    <= OP_RR;
											idx_q   <= rot_q;
											state_q <= S_FETCH;
										end
										MODE_WRR: begin
											op_q    <= OP_W1;
											idx_q   <= '0;
											tot_q   <= '0;
											ofnd_q  <= 1'b0;
											ffnd_q  <= 1'b0;
											fidx_q  <= '0;
											state_q <= S_FETCH;
										end
										MODE_LC: begin
											op_q    <= OP_LC;
											idx_q   <= '0;
											lfnd_q  <= 1'b0;
											pick_q  <= '0;
											state_q <= S_FETCH;
										end
										default: begin
											op_q    <= OP_HP;
											hsh_q   <= hash_q;
											rem_q   <= '0;
											bit_q   <= '0;
											state_q <= S_HMOD;
										end
									endcase
								end
							end
							REQ_BYTE: begin
								v_q     <= 36'({hash_q, 5'd0}) - 36'(hash_q) + 36'(ip_byte);
								red_q   <= 3'd4;
								state_q <= S_HRED;
							end
							default: begin
							end
						endcase
					end
				end
				S_HRED: begin
					if (v_q >= sub) begin
						v_q <= v_q - sub;
					end
					if (red_q == '0) begin
						hash_q  <= (v_q >= sub) ? 30'(v_q - sub) : v_q[29:0];
						state_q <= S_IDLE;
					end else begin
						red_q <= red_q - 3'd1;
					end
				end
				S_HMOD: begin
					rem_q <= rs_red[CW-1:0];
					hsh_q <= {hsh_q[28:0], 1'b0};
					bit_q <= bit_q + 5'd1;
					if (bit_q == 5'(HASH_BITS - 1)) begin
						idx_q   <= rs_red[IW-1:0];
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_CHECK;
				end
				default: begin
					state_q <= S_FETCH;
					k_q     <= k_q + CW'(1);
					idx_q   <= idx_nxt;
					unique case (op_q)
						OP_RR, OP_HP: begin
							if (rd.healthy || last) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
								sidx_q  <= rd.healthy ? 4'(idx_q) : 4'd0;
								stat_q  <= rd.healthy ? STAT_PICK : STAT_FALLBACK;
								if (op_q == OP_RR) begin
									rot_q <= idx_nxt;
								end
							end
						end
						OP_LC: begin
							if (rd.healthy && (!lfnd_q || rd.conns < best_q)) begin
								best_q <= rd.conns;
								pick_q <= idx_q;
								lfnd_q <= 1'b1;
							end
							if (last) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
								if (rd.healthy && (!lfnd_q || rd.conns < best_q)) begin
									sidx_q <= 4'(idx_q);
									stat_q <= STAT_PICK;
								end else begin
									sidx_q <= lfnd_q ? 4'(pick_q) : 4'd0;
									stat_q <= lfnd_q ? STAT_PICK : STAT_FALLBACK;
								end
							end
						end
						OP_W1: begin
							tot_q <= tsum;
							if (own_hit) begin
								own_q  <= idx_q;
								end_q  <= tsum;
								ofnd_q <= 1'b1;
							end
							if (!ffnd_q && rd.weight != 8'd0) begin
								fidx_q <= idx_q;
								ffnd_q <= 1'b1;
							end
							if (last) begin
								k_q <= '0;
								if (tsum == '0) begin
									done_q  <= 1'b1;
									state_q <= S_IDLE;
									sidx_q  <= '0;
									stat_q  <= STAT_EMPTY;
								end else begin
									op_q    <= OP_W2;
									idx_q   <= own_hit ? idx_q : own_q;
									slot_q  <= wpos_q;
									first_q <= 1'b1;
								end
							end
						end
						default: begin
							first_q <= 1'b0;
							slot_q  <= (idx_inc == count_q) ? '0 : seg_end;
							if (rd.weight != 8'd0 && rd.healthy) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
								sidx_q  <= 4'(idx_q);
								stat_q  <= STAT_PICK;
								wpos_q  <= (slot_inc == tot_q) ? '0 : slot_inc;
							end else if (last) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
								sidx_q  <= 4'(fidx_q);
								stat_q  <= STAT_FALLBACK;
							end
						end
					endcase
				end
			endcase
		end
	end

	`HASS_CHECK(a_count_bound, 1'b1, count_q <= CW'(MAX_SERVERS))
	`HASS_CHECK(a_rot_bound, count_q != '0, CW'(rot_q) < count_q)
	`HASS_CHECK(a_walk_bound, state_q == S_FETCH, CW'(idx_q) < count_q)
	`HASS_NEXT(a_add_done, accept && req_type == REQ_ADD, done_q)
endmodule
`default_nettype wire

@@ bench/selector_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// selector_checker
// Watches the config port, the request channel and the result strobe of the
// server selector, predicts every result and compares it field by field.
// ---------------------------------------------------------------------------
module selector_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  req_type,
	input  logic [7:0]  weight,
	input  logic [15:0] connections,
	input  logic        healthy,
	input  logic [7:0]  ip_byte,
	input  logic        done,
	input  logic [3:0]  server_index,
	input  logic [2:0]  status,
	output int          errors,
	output int          pending
);
	import hass_pkg::*;

	localparam int NSRV = 16;
	localparam logic [2:0] ADDR_MODE = 3'd0;

	typedef struct packed {
		logic [3:0] idx;
		logic [2:0] st;
	} pick_t;

	pick_t       picks_due[$];
	logic [1:0]  mode;
	entry_t      table_q[NSRV];
	int unsigned n_entries;
	int unsigned rr_ptr;
	int unsigned slot_pos;
	logic [29:0] hash_acc;

	initial begin
		errors = 0;
		pending = 0;
		mode = MODE_RR;
		n_entries = 0;
		rr_ptr = 0;
		slot_pos = 0;
		hash_acc = '0;
	end

	function automatic int unsigned owner_of(int unsigned s);
		int unsigned acc;
		acc = 0;
		for (int i = 0; i < n_entries; i++) begin
			acc += table_q[i].weight;
			if (s < acc) return i;
		end
		return 0;
	endfunction

	function automatic pick_t choose_server();
		pick_t       r;
		int unsigned p, total, own, best, h;
		logic        found;
		h = hash_acc;
		hash_acc = '0;
		r.idx = 0;
		r.st = STAT_EMPTY;
		if (n_entries == 0) return r;
		case (mode)
			MODE_RR: begin
				p = rr_ptr % n_entries;
				r.st = STAT_FALLBACK;
				for (int i = 0; i < n_entries; i++) begin
					own = p;
					p = (p + 1) % n_entries;
					if (table_q[own].healthy) begin
						r.idx = own;
						r.st = STAT_PICK;
						break;
					end
				end
				rr_ptr = p;
			end
			MODE_WRR: begin
				total = 0;
				for (int i = 0; i < n_entries; i++) total += table_q[i].weight;
				if (total == 0) return r;
				p = slot_pos % total;
				r.st = STAT_FALLBACK;
				r.idx = owner_of(0);
				for (int i = 0; i < total; i++) begin
					own = owner_of(p);
					p = (p + 1) % total;
					if (table_q[own].healthy) begin
						r.idx = own;
						r.st = STAT_PICK;
						break;
					end
				end
				slot_pos = p;
			end
			MODE_LC: begin
				best = 32'h7fffffff;
				found = 0;
				for (int i = 0; i < n_entries; i++)
					if (table_q[i].healthy && table_q[i].conns < best) begin
						best = table_q[i].conns;
						r.idx = i;
						found = 1;
					end
				r.st = found ? STAT_PICK : STAT_FALLBACK;
			end
			default: begin
				r.st = STAT_FALLBACK;
				for (int i = 0; i < n_entries; i++) begin
					own = (h % n_entries + i) % n_entries;
					if (table_q[own].healthy) begin
						r.idx = own;
						r.st = STAT_PICK;
						break;
					end
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		pick_t e;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr[2] == ADDR_MODE[2])
				mode = pwdata[1:0];
			if (done) begin
				if (picks_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: index %0d status %0d",
							server_index, status);
				end else begin
					e = picks_due.pop_front();
					if (e.idx !== server_index || e.st !== status) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: index exp %0d got %0d, status exp %0d got %0d",
								e.idx, server_index, e.st, status);
					end
				end
			end
			if (start && !busy) begin
				case (req_type)
					REQ_ADD: begin
						e.idx = 0;
						e.st = STAT_FULL;
						if (n_entries < NSRV) begin
							table_q[n_entries] = '{weight, connections, healthy};
							e.idx = n_entries;
							e.st = STAT_ADDED;
							n_entries++;
						end
						picks_due.insert(picks_due.size(), e);
					end
					REQ_SEL: picks_due.insert(picks_due.size(), choose_server());
					REQ_BYTE: hash_acc = 30'((64'(hash_acc) * 31 + ip_byte) % 64'd1000000007);
					default: ;
				endcase
			end
			pending = picks_due.size();
		end
	end
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives the server selector with directed and random requests and mode
// changes; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb;
	import hass_pkg::*;

	localparam int LIMIT = 600000;
	localparam int SETTLE = 100;

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        start, busy;
	logic [1:0]  req_type;
	logic [7:0]  weight, ip_byte;
	logic [15:0] connections;
	logic        healthy;
	logic        done;
	logic [3:0]  server_index;
	logic [2:0]  status;
	int          errors, pending;
	int          cycles;

	health_aware_server_selector dut (.*);

	selector_checker chk (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// request stays on the bus until the edge that accepts it
	task automatic send(logic [1:0] t, logic [7:0] w, logic [15:0] c, logic h,
			logic [7:0] b);
		int g;
		g = gap_len();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(negedge clk);
		end
		start <= 1'b1;
		req_type <= t;
		weight <= w;
		connections <= c;
		healthy <= h;
		ip_byte <= b;
		while (busy) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic set_mode(logic [1:0] m);
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0 || busy) @(negedge clk);
		repeat (80) @(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'd0;
		pwdata <= {30'($urandom), m};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_req();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			send(REQ_ADD, ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom),
				16'($urandom), $urandom_range(0, 9) < 7, 8'($urandom));
		else if (r < 35)
			send(REQ_SEL, 8'($urandom), 16'($urandom), 1'($urandom), 8'($urandom));
		else if (r < 95)
			send(REQ_BYTE, 8'($urandom), 16'($urandom), 1'($urandom), 8'($urandom));
		else
			send(2'd3, 8'($urandom), 16'($urandom), 1'($urandom), 8'($urandom));
	endtask

	initial begin
		cycles = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		req_type = REQ_ADD;
		weight = '0;
		connections = '0;
		healthy = 1'b0;
		ip_byte = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty table in every mode
		send(REQ_SEL, 0, 0, 0, 0);
		set_mode(MODE_WRR);
		send(REQ_SEL, 0, 0, 0, 0);
		set_mode(MODE_LC);
		send(REQ_SEL, 0, 0, 0, 0);
		set_mode(MODE_HASH);
		send(REQ_BYTE, 0, 0, 0, 8'hff);
		send(REQ_SEL, 0, 0, 0, 0);
		// unhealthy zero-weight servers: fallbacks and zero total weight
		send(REQ_ADD, 8'd0, 16'd0, 1'b0, 0);
		send(REQ_ADD, 8'd0, 16'hffff, 1'b0, 0);
		send(REQ_BYTE, 0, 0, 0, 8'h00);
		send(REQ_SEL, 0, 0, 0, 0);
		set_mode(MODE_RR);
		send(REQ_SEL, 0, 0, 0, 0);
		set_mode(MODE_WRR);
		send(REQ_SEL, 0, 0, 0, 0);
		send(REQ_ADD, 8'd3, 16'hffff, 1'b0, 0);
		send(REQ_SEL, 0, 0, 0, 0);
		send(REQ_ADD, 8'd255, 16'hffff, 1'b1, 0);
		send(REQ_SEL, 0, 0, 0, 0);
		send(2'd3, 8'hff, 16'hffff, 1'b1, 8'hff);
		set_mode(MODE_LC);
		send(REQ_SEL, 0, 0, 0, 0);
		set_mode(MODE_RR);
		send(REQ_SEL, 0, 0, 0, 0);
		send(REQ_SEL, 0, 0, 0, 0);

		for (int ph = 0; ph < 16; ph++) begin
			set_mode(ph < 4 ? 2'(3 - ph) : 2'($urandom));
			repeat (56) random_req();
		end

		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

@@ health_aware_server_selector.f @@
+incdir+rtl/core
rtl/core/hass_pkg.sv
rtl/core/hass_ram.sv
rtl/core/health_aware_server_selector.sv
bench/selector_checker.sv
bench/tb.sv
